### hw/rtl/fr_pkg.sv
// Shared types and constants for the fraction reducer.
package fr_pkg;

  // Word width of numerator, denominator and results
  localparam int unsigned WordBits = 32;
  localparam int unsigned CountBits = $clog2(WordBits);

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StZeroDen  = 2'd1,
    StOverflow = 2'd2
  } fr_status_e;

  typedef struct packed {
    logic signed [WordBits-1:0] numerator;
    logic signed [WordBits-1:0] denominator;
  } fr_in_t;

  typedef struct packed {
    logic signed [WordBits-1:0] reduced_numerator;
    logic        [WordBits-1:0] reduced_denominator;
    fr_status_e                 status;
  } fr_out_t;

  // Start request to an iterative unit
  typedef struct packed {
    logic                start;
    logic [WordBits-1:0] op_a;
    logic [WordBits-1:0] op_b;
  } fr_req_t;

endpackage

### hw/rtl/fr_gcd.sv
// Binary GCD unit: one shift or subtract step per cycle.
module fr_gcd (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fr_pkg::fr_req_t                  req_i,
  output logic                             done_o,
  output logic [fr_pkg::WordBits-1:0]      gcd_o
);

  localparam int unsigned W = fr_pkg::WordBits;

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [W-1:0]                    a_q, a_d, b_q, b_d, g_q, g_d;
  logic [fr_pkg::CountBits-1:0]    k_q, k_d;
  logic [W:0]                      diff_ab, diff_ba;

  // Shared subtractor pair, also serving as the magnitude compare
  assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
  assign diff_ba = {1'b0, b_q} - {1'b0, a_q};

  // One step of the reduction
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    g_d    = g_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      a_d    = req_i.op_a;
      b_d    = req_i.op_b;
      k_d    = '0;
    end else if (busy_q) begin
      if (a_q == b_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        g_d    = a_q << k_q;
      end else if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (!diff_ab[W]) begin
        a_d = diff_ab[W:1];
      end else begin
        b_d = diff_ba[W:1];
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Operands and result
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
    g_q <= g_d;
  end

  assign done_o = done_q;
  assign gcd_o  = g_q;

endmodule

### hw/rtl/fr_div.sv
// Restoring divider: one quotient bit per cycle, used for both divisions.
module fr_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fr_pkg::fr_req_t                  req_i,
  output logic                             done_o,
  output logic [fr_pkg::WordBits-1:0]      quotient_o
);

  localparam int unsigned W = fr_pkg::WordBits;
  localparam logic [fr_pkg::CountBits-1:0] LastCount = fr_pkg::CountBits'(W - 1);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [W-1:0]                    rem_q, rem_d, quo_q, quo_d, div_q, div_d;
  logic [fr_pkg::CountBits-1:0]    cnt_q, cnt_d;
  logic [W:0]                      trial;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_q, quo_q[W-1]} - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      rem_d  = '0;
      quo_d  = req_i.op_a;
      div_d  = req_i.op_b;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCount) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
    cnt_q <= cnt_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hw/rtl/fraction_reducer_core.sv
// Fraction reducer top level: sequencer around the GCD unit and the divider.
//
//   channel | direction | payload          | handshake
//   in      | input     | fr_pkg::fr_in_t  | in_valid_i / in_stall_o
//   out     | output    | fr_pkg::fr_out_t | out_valid_o / out_stall_i
//
// One item at a time. A zero numerator or denominator goes straight from acceptance to
// the output hand-off; any other item passes through the binary GCD unit, then the
// divider for the numerator and then the divider for the denominator.
// in_stall_o is high from acceptance until the result moves to the output register.
// A stalled result holds there while the next item is taken in. Reset clears the
// sequencer and the output valid.
module fraction_reducer_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  fr_pkg::fr_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output fr_pkg::fr_out_t out_data_o
);

  localparam int unsigned W = fr_pkg::WordBits;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StGcd  = 3'd1;
  localparam logic [2:0] StDivN = 3'd2;
  localparam logic [2:0] StDivD = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [W-1:0]      nmag_q, nmag_d, dmag_q, dmag_d, rn_q, rn_d;
  logic              neg_q, neg_d;
  fr_pkg::fr_out_t   res_q, res_d;
  fr_pkg::fr_out_t   out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              in_xfer, out_xfer;
  logic              nneg, dneg;
  logic [W-1:0]      nraw, draw, nmag_in, dmag_in, rn_fin;
  fr_pkg::fr_req_t   gcd_req, div_req;
  logic              gcd_done, div_done;
  logic [W-1:0]      gcd_val, quo_val;

  assign in_xfer  = in_valid_i && (state_q == StIdle);
  assign out_xfer = out_valid_q && !out_stall_i;
  // Output register can take a new result this cycle
  assign out_free = !out_valid_q || out_xfer;

  // Sign and magnitude of the incoming operands
  assign nraw    = in_data_i.numerator;
  assign draw    = in_data_i.denominator;
  assign nneg    = nraw[W-1];
  assign dneg    = draw[W-1];
  assign nmag_in = nneg ? (W'(0) - nraw) : nraw;
  assign dmag_in = dneg ? (W'(0) - draw) : draw;

  // Sign applied to the reduced numerator
  assign rn_fin = neg_q ? (W'(0) - rn_q) : rn_q;

  // Sequencer
  always_comb begin
    state_d       = state_q;
    nmag_d        = nmag_q;
    dmag_d        = dmag_q;
    rn_d          = rn_q;
    neg_d         = neg_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_xfer;
    gcd_req       = '0;
    div_req       = '0;
    gcd_req.op_a  = nmag_in;
    gcd_req.op_b  = dmag_in;
    div_req.op_a  = nmag_q;
    div_req.op_b  = gcd_val;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          nmag_d = nmag_in;
          dmag_d = dmag_in;
          neg_d  = nneg ^ dneg;
          if (dmag_in == '0) begin
            res_d.reduced_numerator   = '0;
            res_d.reduced_denominator = W'(1);
            res_d.status              = fr_pkg::StZeroDen;
            state_d                   = StOut;
          end else if (nmag_in == '0) begin
            res_d.reduced_numerator   = '0;
            res_d.reduced_denominator = W'(1);
            res_d.status              = fr_pkg::StOk;
            state_d                   = StOut;
          end else begin
            gcd_req.start = 1'b1;
            state_d       = StGcd;
          end
        end
      end
      StGcd: begin
        if (gcd_done) begin
          div_req.start = 1'b1;
          state_d       = StDivN;
        end
      end
      StDivN: begin
        if (div_done) begin
          rn_d          = quo_val;
          div_req.start = 1'b1;
          div_req.op_a  = dmag_q;
          state_d       = StDivD;
        end
      end
      StDivD: begin
        if (div_done) begin
          res_d.reduced_denominator = quo_val;
          res_d.reduced_numerator   = rn_fin;
          res_d.status              = fr_pkg::StOk;
          // Positive result one past the largest positive word saturates
          if (!neg_q && rn_q[W-1]) begin
            res_d.reduced_numerator = {1'b0, {(W-1){1'b1}}};
            res_d.status            = fr_pkg::StOverflow;
          end
          state_d = StOut;
        end
      end
      StOut: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Sequencer state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk_i) begin
    nmag_q <= nmag_d;
    dmag_q <= dmag_d;
    rn_q   <= rn_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  fr_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gcd_req),
    .done_o (gcd_done),
    .gcd_o  (gcd_val)
  );

  fr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (quo_val)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### tb/sv/fraction_reducer_checker.sv
// Scoreboard for the fraction reducer: predicts each reduced fraction and checks the results.
module fraction_reducer_checker
  import fr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_stall_i,
  input  fr_in_t  in_data_i,
  input  logic    out_valid_i,
  input  logic    out_stall_i,
  input  fr_out_t out_data_i,
  output int      error_count_o,
  output int      pending_o,
  output int      reduced_count_o,
  output int      zero_den_count_o,
  output int      saturated_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [WordBits-1:0] word_t;

  // Largest positive value a result numerator can hold
  localparam word_t MaxPos = {1'b0, {(WordBits-1){1'b1}}};

  typedef struct {
    fr_in_t  source;
    fr_out_t result;
  } fraction_pair_t;

  fraction_pair_t expected_fractions[$];
  fraction_pair_t wanted;
  fraction_pair_t entry;

  // Sign goes to the numerator, both magnitudes divided by Euclid's GCD
  function automatic fr_out_t reduce_fraction(fr_in_t frac);
    fr_out_t res;
    word_t   num_mag;
    word_t   den_mag;
    word_t   a;
    word_t   b;
    word_t   rem;
    word_t   quo;
    logic    num_neg;
    logic    den_neg;
    num_neg = frac.numerator[WordBits-1];
    den_neg = frac.denominator[WordBits-1];
    // Negating the most negative word leaves the bit pattern of 2^(W-1), which is exact
    num_mag = num_neg ? word_t'(-frac.numerator) : word_t'(frac.numerator);
    den_mag = den_neg ? word_t'(-frac.denominator) : word_t'(frac.denominator);
    res.reduced_numerator   = '0;
    res.reduced_denominator = word_t'(1);
    res.status              = StOk;
    if (den_mag == '0) begin
      res.status = StZeroDen;
    end else if (num_mag != '0) begin
      a = num_mag;
      b = den_mag;
      while (b != '0) begin
        rem = a % b;
        a   = b;
        b   = rem;
      end
      quo = num_mag / a;
      res.reduced_denominator = den_mag / a;
      if (num_neg != den_neg) begin
        res.reduced_numerator = -quo;
      end else if (quo > MaxPos) begin
        // Only the most negative numerator over a negative denominator gets here
        res.reduced_numerator = MaxPos;
        res.status            = StOverflow;
      end else begin
        res.reduced_numerator = quo;
      end
    end
    return res;
  endfunction

  function automatic void report_mismatch(string field, longint want_val, longint got_val,
                                          fr_in_t src);
    error_count_o++;
    $display("%0t: %s expected %0d actual %0d (input %0d/%0d)", $time, field, want_val,
             got_val, src.numerator, src.denominator);
  endfunction

  // Results are checked before the new transfer is queued, so a result can
  // never be matched against the item accepted on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_fractions.size() == 0) begin
          error_count_o++;
          $display("%0t: result %0d/%0d status %0d with nothing expected", $time,
                   out_data_i.reduced_numerator, out_data_i.reduced_denominator,
                   out_data_i.status);
        end else begin
          wanted = expected_fractions.pop_front();
          reduced_count_o++;
          if (out_data_i.reduced_numerator !== wanted.result.reduced_numerator) begin
            report_mismatch("reduced_numerator", wanted.result.reduced_numerator,
                            out_data_i.reduced_numerator, wanted.source);
          end
          if (out_data_i.reduced_denominator !== wanted.result.reduced_denominator) begin
            report_mismatch("reduced_denominator", wanted.result.reduced_denominator,
                            out_data_i.reduced_denominator, wanted.source);
          end
          if (out_data_i.status !== wanted.result.status) begin
            report_mismatch("status", wanted.result.status, out_data_i.status,
                            wanted.source);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        entry.source = in_data_i;
        entry.result = reduce_fraction(in_data_i);
        if (entry.result.status == StZeroDen) zero_den_count_o++;
        if (entry.result.status == StOverflow) saturated_count_o++;
        expected_fractions.push_back(entry);
      end
      pending_o <= expected_fractions.size();
    end
  end

endmodule

### tb/sv/fraction_reducer_core_test.sv
// Testbench top for the fraction reducer: clock, reset, stimulus, flow control and verdict.
module fraction_reducer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fr_pkg::*;

  typedef logic [WordBits-1:0] word_t;

  localparam word_t MinWord     = {1'b1, {(WordBits-1){1'b0}}};
  localparam word_t MaxWord     = {1'b0, {(WordBits-1){1'b1}}};
  localparam int    PhaseItems  = 550;
  localparam int    HoldCycles  = 400;
  localparam int    DrainCycles = 200;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  fr_in_t  in_data   = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  fr_out_t out_data;
  logic    hold_off  = 1'b0;

  int sender_idle_pct   = 38;
  int receiver_idle_pct = 65;
  int sent_count;
  int error_count;
  int pending;
  int reduced_count;
  int zero_den_count;
  int saturated_count;

  // Idle percentages per phase: receiver idles more, then sender idles more, then none
  int sender_pcts[3]   = '{38, 65, 0};
  int receiver_pcts[3] = '{65, 38, 0};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fraction_reducer_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  fraction_reducer_checker u_reduce_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .error_count_o    (error_count),
    .pending_o        (pending),
    .reduced_count_o  (reduced_count),
    .zero_den_count_o (zero_den_count),
    .saturated_count_o(saturated_count)
  );

  // Receiver: random stalls, forced high during the hold-off
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < receiver_idle_pct);
  end

  // Long output hold-off early in the no-idle phase; the sender keeps offering
  initial begin
    while (sent_count < 2 * PhaseItems + 80) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Offer one fraction and hold it until the transfer completes
  task automatic send_fraction(input word_t num, input word_t den);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{numerator: num, denominator: den};
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  function automatic word_t special_word();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return word_t'(1);
      2:       return '1;
      3:       return MinWord;
      4:       return MaxWord;
      5:       return MinWord + 1'b1;
      default: return word_t'(1) << (WordBits - 2);
    endcase
  endfunction

  // Mix of full-range words, small values, shared factors, extremes and
  // most-negative numerators that can overflow
  function automatic fr_in_t random_fraction();
    fr_in_t frac;
    word_t  factor;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        frac.numerator   = $urandom;
        frac.denominator = $urandom;
      end
      4, 5: begin
        frac.numerator   = $urandom_range(0, 40);
        frac.denominator = $urandom_range(0, 40);
      end
      6, 7: begin
        factor           = $urandom_range(1, 1 << 15);
        frac.numerator   = factor * $urandom_range(0, 30000);
        frac.denominator = factor * $urandom_range(1, 30000);
      end
      8: begin
        frac.numerator   = special_word();
        frac.denominator = special_word();
      end
      default: begin
        frac.numerator   = MinWord;
        frac.denominator = $urandom_range(0, 1) ? word_t'(1) << $urandom_range(0, WordBits - 1)
                                                : word_t'($urandom_range(0, 999) | 1);
      end
    endcase
    if ($urandom_range(0, 1)) frac.numerator = -frac.numerator;
    if ($urandom_range(0, 1)) frac.denominator = -frac.denominator;
    return frac;
  endfunction

  initial begin
    fr_in_t item;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero numerator and zero denominator
    send_fraction('0, word_t'(5));
    send_fraction('0, -word_t'(7));
    send_fraction(word_t'(9), '0);
    send_fraction('0, '0);
    send_fraction(MinWord, '0);
    // Sign handling
    send_fraction(word_t'(12), -word_t'(18));
    send_fraction(-word_t'(12), -word_t'(18));
    send_fraction(word_t'(1), word_t'(1));
    send_fraction('1, '1);
    // Most negative numerator: saturating and non-saturating cases
    send_fraction(MinWord, '1);
    send_fraction(MinWord, -word_t'(3));
    send_fraction(MinWord, -word_t'(2));
    send_fraction(MinWord, MinWord);
    send_fraction(MinWord, word_t'(1));
    send_fraction(MinWord, word_t'(3));
    // Most negative denominator as a reduced denominator
    send_fraction(MaxWord, MinWord);
    send_fraction(word_t'(1), MinWord);
    // Large coprime and worst-case Euclid inputs
    send_fraction(MaxWord, MaxWord);
    send_fraction(-MaxWord, '1);
    send_fraction(MaxWord, MaxWord - 1'b1);
    send_fraction(word_t'(1836311903), word_t'(1134903170));
    send_fraction(word_t'(1) << 30, word_t'(1) << 20);
    send_fraction('1, MaxWord);

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = sender_pcts[phase];
      receiver_idle_pct = receiver_pcts[phase];
      repeat (PhaseItems) begin
        item = random_fraction();
        send_fraction(item.numerator, item.denominator);
      end
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray results
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Reduced %0d fractions, %0d with zero denominator and %0d saturated,",
             reduced_count, zero_den_count, saturated_count);
    $display("under sender/receiver idling 38/65, 65/38 and none, plus a %0d-cycle hold-off.",
             HoldCycles);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### fraction_reducer_core.f
hw/rtl/fr_pkg.sv
hw/rtl/fr_gcd.sv
hw/rtl/fr_div.sv
hw/rtl/fraction_reducer_core.sv
tb/sv/fraction_reducer_checker.sv
tb/sv/fraction_reducer_core_test.sv
